// ===== sv/pms_pkg.sv =====
`timescale 1ns / 1ps
package pms_pkg;

  // Widest slot address over the supported memory sizes.
  localparam int ADDR_W_MAX = 10;
  // The stack index field is three bits, so at most eight fill counters are addressable.
  localparam int STACK_SLOTS = 8;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } pms_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NOSTACK = 2'd3
  } pms_status_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         stack_index;
    logic signed [31:0] push_value;
  } pms_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
  } pms_out_t;

  // Command handed from the front end to the memory side.
  typedef struct packed {
    logic [1:0]            status;
    logic                  rd;
    logic                  wr;
    logic [ADDR_W_MAX-1:0] addr;
    logic [31:0]           data;
  } pms_cmd_t;

endpackage

// ===== sv/partitioned_multi_stack.sv =====
`timescale 1ns / 1ps
// Several LIFO stacks in one slot memory, each owning an equal region of it.
// Input beats (in_valid/in_stall/in_data) carry an opcode (push, pop, peek),
// a stack index and a push value. Each accepted beat yields exactly one result
// beat (out_valid/out_stall/out_data) with a status and the value read.
// The front end checks the index and fill counts and updates the counts when
// the beat is taken; a two-entry queue hands the memory access to the back end,
// which reads or writes the slot memory and holds the result in a register.
// The result passes the back-end stage and the output register. Throughput:
// one beat per cycle while out_stall is low, set by the single memory port.
// While out_stall is high, results back up into the back end and the queue;
// in_stall rises once the queue is full, and no beat is lost.
// cfg_we with cfg_wdata sets the stack count and empties all stacks; the user
// must write it only while no beat is in flight; the block does not enforce it.
// Reset (rst_n low, synchronous) sets one stack, empties it and clears the
// queue and the output valid flag. Slot contents are not cleared.
module partitioned_multi_stack #(
  parameter int TOTAL_SLOTS = 16,
  parameter int MAX_STACKS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pms_pkg::pms_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pms_pkg::pms_out_t out_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);
  import pms_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  pms_cmd_t q_in;
  pms_cmd_t q_head;

  pms_front #(
    .TOTAL_SLOTS(TOTAL_SLOTS),
    .MAX_STACKS (MAX_STACKS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  pms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .empty    (q_empty),
    .pop      (q_pop),
    .head     (q_head)
  );

  pms_back #(
    .TOTAL_SLOTS(TOTAL_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_head   (q_head),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== sv/pms_front.sv =====
`timescale 1ns / 1ps
module pms_front #(
  parameter int TOTAL_SLOTS = 16,
  parameter int MAX_STACKS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pms_pkg::pms_in_t  in_data,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  logic              q_full,
  output logic              q_push,
  output pms_pkg::pms_cmd_t q_data
);
  import pms_pkg::*;

  localparam int CW = $clog2(TOTAL_SLOTS + 1);
  localparam logic [3:0] KCAP = (MAX_STACKS > 15) ? 4'd15 : 4'(MAX_STACKS);

  logic [CW-1:0] region_tbl [16];
  logic [3:0]    k_r, k_nxt;
  logic [CW-1:0] region_r;
  logic [CW-1:0] fill_r [STACK_SLOTS];
  logic          accept;
  logic [CW-1:0] cnt;
  logic [31:0]   base;
  logic [31:0]   addr_w;
  logic [CW-1:0] cnt_nxt;
  logic          cnt_we;

  // Region size for every possible stack count, fixed at elaboration.
  for (genvar i = 0; i < 16; i++) begin : g_region
    localparam int REGION = TOTAL_SLOTS / ((i == 0) ? 1 : i);
    assign region_tbl[i] = CW'(REGION);
  end

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign q_push   = accept;

  always_comb begin
    if (cfg_wdata == 4'd0) begin
      k_nxt = 4'd1;
    end else if (cfg_wdata > KCAP) begin
      k_nxt = KCAP;
    end else begin
      k_nxt = cfg_wdata;
    end
  end

  assign cnt  = fill_r[in_data.stack_index];
  assign base = 32'(in_data.stack_index) * 32'(region_r);

  always_comb begin
    q_data        = '0;
    q_data.status = ST_OK;
    q_data.data   = in_data.push_value;
    cnt_nxt       = cnt;
    cnt_we        = 1'b0;
    addr_w        = base + 32'(cnt);
    case (in_data.opcode)
      OP_PUSH, OP_POP, OP_PEEK: begin
        if ({1'b0, in_data.stack_index} >= k_r) begin
          q_data.status = ST_NOSTACK;
        end else if (in_data.opcode == OP_PUSH) begin
          if (cnt >= region_r) begin
            q_data.status = ST_FULL;
          end else begin
            q_data.wr = 1'b1;
            cnt_nxt   = cnt + 1'b1;
            cnt_we    = 1'b1;
          end
        end else if (cnt == '0) begin
          q_data.status = ST_EMPTY;
        end else begin
          addr_w    = base + 32'(cnt) - 32'd1;
          q_data.rd = 1'b1;
          if (in_data.opcode == OP_POP) begin
            cnt_nxt = cnt - 1'b1;
            cnt_we  = 1'b1;
          end
        end
      end
      default: begin
        q_data.status = ST_OK;
      end
    endcase
    q_data.addr = addr_w[ADDR_W_MAX-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= 4'd1;
      region_r <= CW'(TOTAL_SLOTS);
      for (int i = 0; i < STACK_SLOTS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (cfg_we) begin
      // Reconfiguration empties every stack.
      k_r      <= k_nxt;
      region_r <= region_tbl[k_nxt];
      for (int i = 0; i < STACK_SLOTS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (accept && cnt_we) begin
      fill_r[in_data.stack_index] <= cnt_nxt;
    end
  end

endmodule

// ===== sv/pms_queue.sv =====
`timescale 1ns / 1ps
module pms_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pms_pkg::pms_cmd_t push_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output pms_pkg::pms_cmd_t head
);
  import pms_pkg::*;

  pms_cmd_t   buf_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/pms_back.sv =====
`timescale 1ns / 1ps
module pms_back #(
  parameter int TOTAL_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  pms_pkg::pms_cmd_t q_head,
  output logic              out_valid,
  input  logic              out_stall,
  output pms_pkg::pms_out_t out_data
);
  import pms_pkg::*;

  localparam int SLOT_AW = $clog2(TOTAL_SLOTS);

  logic [31:0]      mem [TOTAL_SLOTS];
  logic [31:0]      rd_data_r;
  logic             s1_valid_r;
  logic [1:0]       s1_status_r;
  logic             s1_rd_r;
  logic             s1_adv;
  logic             out_valid_r;
  pms_out_t         out_r;
  logic [SLOT_AW-1:0] addr;

  assign addr      = q_head.addr[SLOT_AW-1:0];
  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign q_pop     = ~q_empty & (~s1_valid_r | s1_adv);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_head.wr) begin
      mem[addr] <= q_head.data;
    end
    if (q_pop && q_head.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_status_r <= q_head.status;
      s1_rd_r     <= q_head.rd;
    end
    if (s1_adv) begin
      out_r.status     <= s1_status_r;
      out_r.read_value <= s1_rd_r ? rd_data_r : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
